/* design/tcms_pkg.sv */
`timescale 1ns / 1ps
// Types, constants and the ordering function for the multi-key record sorter.
// Used by the interfaces, the classifier, the sort cell and the top level.
package tcms_pkg;

  localparam int MAX_RECORDS_DEF = 32;
  localparam int ID_W    = 32;
  localparam int SCORE_W = 8;
  localparam int GROUP_W = 2;
  localparam int CNT_W   = 6;
  localparam int TOTAL_W = SCORE_W + 1;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_LOW_LINE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_LINE = 1'b1;

  localparam logic [GROUP_W-1:0] GRP_BOTH_HIGH  = 2'd0;
  localparam logic [GROUP_W-1:0] GRP_FIRST_HIGH = 2'd1;
  localparam logic [GROUP_W-1:0] GRP_FIRST_GE   = 2'd2;
  localparam logic [GROUP_W-1:0] GRP_OTHER      = 2'd3;

  localparam logic [CFG_DATA_W-1:0] LOW_LINE_RST  = 8'd60;
  localparam logic [CFG_DATA_W-1:0] HIGH_LINE_RST = 8'd80;

  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [SCORE_W-1:0] first;
    logic [SCORE_W-1:0] second;
    logic [GROUP_W-1:0] group;
  } rec_t;

  typedef struct packed {
    logic ins_en;
    logic shift_en;
    logic clr;
  } cell_ctl_t;

  typedef enum logic [2:0] {
    ST_LOAD  = 3'b001,
    ST_COUNT = 3'b010,
    ST_DRAIN = 3'b100
  } state_t;

  function automatic logic goes_before(input rec_t x, input rec_t y);
    logic [TOTAL_W-1:0] tx;
    logic [TOTAL_W-1:0] ty;
    logic               res;
    tx = {1'b0, x.first} + {1'b0, x.second};
    ty = {1'b0, y.first} + {1'b0, y.second};
    if (x.group != y.group) begin
      res = (x.group < y.group);
    end else if (tx != ty) begin
      res = (tx > ty);
    end else if (x.first != y.first) begin
      res = (x.first > y.first);
    end else begin
      res = (x.id < y.id);
    end
    return res;
  endfunction

endpackage

/* design/tcms_if.sv */
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the record input and the result output.
// Depends on tcms_pkg for field widths.
interface tcms_in_if import tcms_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [ID_W-1:0]    record_id;
  logic [SCORE_W-1:0] first_score;
  logic [SCORE_W-1:0] second_score;
  logic               final_record;

  modport source (output valid, record_id, first_score, second_score, final_record,
                  input ready);
  modport sink (input valid, record_id, first_score, second_score, final_record,
                output ready);
endinterface

interface tcms_out_if import tcms_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               item_kind;
  logic [CNT_W-1:0]   admitted_count;
  logic               overflow_flag;
  logic [ID_W-1:0]    out_id;
  logic [SCORE_W-1:0] out_first_score;
  logic [SCORE_W-1:0] out_second_score;
  logic [GROUP_W-1:0] out_group;
  logic               last_result;

  modport source (output valid, item_kind, admitted_count, overflow_flag, out_id,
                  out_first_score, out_second_score, out_group, last_result,
                  input ready);
  modport sink (input valid, item_kind, admitted_count, overflow_flag, out_id,
                out_first_score, out_second_score, out_group, last_result,
                output ready);
endinterface

/* design/tcms_classify.sv */
`timescale 1ns / 1ps
// Admission check and group decision for one incoming record.
// Depends on tcms_pkg.
module tcms_classify import tcms_pkg::*; (
  input  logic [SCORE_W-1:0]    first,
  input  logic [SCORE_W-1:0]    second,
  input  logic [CFG_DATA_W-1:0] low_line,
  input  logic [CFG_DATA_W-1:0] high_line,
  output logic                  admit,
  output logic [GROUP_W-1:0]    group
);

  always_comb begin
    admit = (first >= low_line) && (second >= low_line);
    priority if ((first >= high_line) && (second >= high_line)) begin
      group = GRP_BOTH_HIGH;
    end else if (first >= high_line) begin
      group = GRP_FIRST_HIGH;
    end else if (first >= second) begin
      group = GRP_FIRST_GE;
    end else begin
      group = GRP_OTHER;
    end
  end

endmodule

/* design/tcms_cell.sv */
`timescale 1ns / 1ps
// One cell of the sorted chain: holds a record, compares against the broadcast
// record and shifts to/from its neighbors. Depends on tcms_pkg.
module tcms_cell import tcms_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  cell_ctl_t ctl,
  input  rec_t      new_rec,
  input  rec_t      prev_data,
  input  logic      prev_valid,
  input  logic      prev_ins,
  input  rec_t      next_data,
  input  logic      next_valid,
  output rec_t      data,
  output logic      valid,
  output logic      ins
);

  rec_t data_r, data_nxt;
  logic valid_r, valid_nxt;

  assign ins   = !valid_r || goes_before(new_rec, data_r);
  assign data  = data_r;
  assign valid = valid_r;

  always_comb begin
    data_nxt  = data_r;
    valid_nxt = valid_r;
    if (ctl.clr) begin
      valid_nxt = 1'b0;
    end else if (ctl.shift_en) begin
      data_nxt  = next_data;
      valid_nxt = next_valid;
    end else if (ctl.ins_en && ins) begin
      if (prev_ins) begin
        data_nxt  = prev_data;
        valid_nxt = prev_valid;
      end else begin
        data_nxt  = new_rec;
        valid_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

endmodule

/* design/threshold_classify_multikey_sorter.sv */
`timescale 1ns / 1ps
// Threshold classify and multi-key record sorter, top level.
// Depends on tcms_pkg, tcms_if, tcms_classify and tcms_cell.
//
// Usage: records arrive on in_if (valid/ready). Each record is checked against
// low_line/high_line (cfg port, index 0 and 1), given a group and inserted in a
// row of MAX_RECORDS sort cells when accepted, so loading runs at one item per
// cycle. A record with final_record set is stored like the others; the next
// cycle the count item appears on out_if, followed by one sorted record per
// accepted output item, shifted out of the head cell of the row.
// Output of N stored records takes N+1 items, one per cycle when out_if.ready
// stays high. in_if.ready is low from the final record until the last result
// (last_result = 1) is taken. A stall on out_if simply holds the current item.
// Records admitted while the row is full are dropped and overflow_flag is set
// for the whole output run. Reset empties the row, clears count and flag and
// loads the register defaults 60 and 80. No clearing pass is needed.
module threshold_classify_multikey_sorter import tcms_pkg::*; #(
  parameter int MAX_RECORDS = MAX_RECORDS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  tcms_in_if.sink               in_if,
  tcms_out_if.source            out_if,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  state_t state_r, state_nxt;
  logic [CFG_DATA_W-1:0] low_r, high_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic mark_r, mark_nxt;

  rec_t new_rec;
  logic admit;
  logic [GROUP_W-1:0] grp;
  logic in_acc, out_acc, full;
  cell_ctl_t ctl;

  rec_t cell_data  [MAX_RECORDS];
  logic cell_valid [MAX_RECORDS];
  logic cell_ins   [MAX_RECORDS];

  tcms_classify u_classify (
    .first     (in_if.first_score),
    .second    (in_if.second_score),
    .low_line  (low_r),
    .high_line (high_r),
    .admit     (admit),
    .group     (grp)
  );

  assign new_rec = '{id: in_if.record_id, first: in_if.first_score,
                     second: in_if.second_score, group: grp};

  assign in_if.ready = (state_r == ST_LOAD);
  assign in_acc  = in_if.valid && in_if.ready;
  assign out_acc = out_if.valid && out_if.ready;
  assign full    = cell_valid[MAX_RECORDS-1];

  always_comb begin
    ctl.ins_en   = in_acc && admit && !full;
    ctl.shift_en = (state_r == ST_DRAIN) && out_acc;
    ctl.clr      = 1'b0;
  end

  genvar gi;
  generate
    for (gi = 0; gi < MAX_RECORDS; gi++) begin : g_cell
      rec_t p_data, n_data;
      logic p_valid, p_ins, n_valid;
      if (gi == 0) begin : g_head
        assign p_data  = '0;
        assign p_valid = 1'b0;
        assign p_ins   = 1'b0;
      end else begin : g_body
        assign p_data  = cell_data[gi-1];
        assign p_valid = cell_valid[gi-1];
        assign p_ins   = cell_ins[gi-1];
      end
      if (gi == MAX_RECORDS - 1) begin : g_tail
        assign n_data  = '0;
        assign n_valid = 1'b0;
      end else begin : g_mid
        assign n_data  = cell_data[gi+1];
        assign n_valid = cell_valid[gi+1];
      end
      tcms_cell u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .new_rec    (new_rec),
        .prev_data  (p_data),
        .prev_valid (p_valid),
        .prev_ins   (p_ins),
        .next_data  (n_data),
        .next_valid (n_valid),
        .data       (cell_data[gi]),
        .valid      (cell_valid[gi]),
        .ins        (cell_ins[gi])
      );
    end
  endgenerate

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    mark_nxt  = mark_r;
    unique case (state_r)
      ST_LOAD: begin
        if (in_acc) begin
          if (admit && full) begin
            mark_nxt = 1'b1;
          end else if (admit) begin
            cnt_nxt = cnt_r + CNT_W'(1);
          end
          if (in_if.final_record) begin
            state_nxt = ST_COUNT;
          end
        end
      end
      ST_COUNT: begin
        if (out_acc) begin
          if (cnt_r == '0) begin
            state_nxt = ST_LOAD;
            mark_nxt  = 1'b0;
          end else begin
            state_nxt = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        if (out_acc && !cell_valid[1]) begin
          state_nxt = ST_LOAD;
          cnt_nxt   = '0;
          mark_nxt  = 1'b0;
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      cnt_r   <= '0;
      mark_r  <= 1'b0;
      low_r   <= LOW_LINE_RST;
      high_r  <= HIGH_LINE_RST;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      mark_r  <= mark_nxt;
      if (cfg_we && cfg_index == REG_LOW_LINE) begin
        low_r <= cfg_wdata;
      end
      if (cfg_we && cfg_index == REG_HIGH_LINE) begin
        high_r <= cfg_wdata;
      end
    end
  end

  always_comb begin
    out_if.valid            = (state_r == ST_COUNT) || (state_r == ST_DRAIN);
    out_if.item_kind        = (state_r == ST_DRAIN);
    out_if.overflow_flag    = mark_r;
    out_if.admitted_count   = (state_r == ST_DRAIN) ? '0 : cnt_r;
    out_if.out_id           = (state_r == ST_DRAIN) ? cell_data[0].id : '0;
    out_if.out_first_score  = (state_r == ST_DRAIN) ? cell_data[0].first : '0;
    out_if.out_second_score = (state_r == ST_DRAIN) ? cell_data[0].second : '0;
    out_if.out_group        = (state_r == ST_DRAIN) ? cell_data[0].group : '0;
    out_if.last_result      = (state_r == ST_DRAIN) ? !cell_valid[1] : (cnt_r == '0);
  end

endmodule

/* design/tcms_checker.sv */
`timescale 1ns / 1ps
// Port-level assertions for the multi-key record sorter, bound to the top level.
// Depends on tcms_pkg.
module tcms_checker import tcms_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic             in_final,
  input logic             out_valid,
  input logic             out_ready,
  input logic             out_kind,
  input logic [CNT_W-1:0] out_count,
  input logic             out_last
);

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |-> !out_valid)
    else $error("input taken while results pending");

  a_count_follows_final: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_final |=> out_valid && !out_kind)
    else $error("count item missing after final record");

  a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_kind && out_count == '0 |-> out_last)
    else $error("empty set count item not marked last");

  a_record_count_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind |-> out_count == '0)
    else $error("record item carries a count");

  a_ready_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_last |=> in_ready && !out_valid)
    else $error("block not back to loading after last result");

endmodule

bind threshold_classify_multikey_sorter tcms_checker u_tcms_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_if.valid),
  .in_ready  (in_if.ready),
  .in_final  (in_if.final_record),
  .out_valid (out_if.valid),
  .out_ready (out_if.ready),
  .out_kind  (out_if.item_kind),
  .out_count (out_if.admitted_count),
  .out_last  (out_if.last_result)
);

/* tb/threshold_classify_multikey_sorter_tb.sv */
`timescale 1ns / 1ps
// Self-checking bench for threshold_classify_multikey_sorter. It drives record sets with random
// gaps and output stalls, ranks admitted records in a local chain and checks every result item.
// Depends on tcms_pkg, tcms_in_if / tcms_out_if and the sorter RTL.
module threshold_classify_multikey_sorter_tb import tcms_pkg::*;;

  localparam logic KIND_COUNT   = 1'b0;
  localparam logic KIND_RECORD  = 1'b1;
  localparam int   CYCLE_LIMIT  = 200000;
  localparam int   IDLE_PCT     = 37;
  localparam int   RANDOM_ITEMS = 380;
  localparam int   HOLD_CYCLES  = 300;
  localparam int   PRINT_LIMIT  = 40;

  typedef struct packed {
    logic               kind;
    logic [CNT_W-1:0]   count;
    logic               ovf;
    logic [ID_W-1:0]    id;
    logic [SCORE_W-1:0] first;
    logic [SCORE_W-1:0] second;
    logic [GROUP_W-1:0] group;
    logic               last;
  } result_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  tcms_in_if  rec_ch ();
  tcms_out_if res_ch ();

  threshold_classify_multikey_sorter u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (rec_ch.sink),
    .out_if    (res_ch.source),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  logic [SCORE_W-1:0] low_line_q;
  logic [SCORE_W-1:0] high_line_q;
  rec_t               sorted_chain[$];
  logic               chain_dropped;
  result_t            due_results[$];

  int   errors;
  int   sets_sent;
  int   records_sent;
  int   results_checked;
  int   cycle_count;
  logic steady;
  logic hold_pending = 1'b0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("threshold_classify_multikey_sorter_tb: errors");
      $finish;
    end
  end

  // lower key ranks first: group up, total down, first score down, id up
  function automatic logic [50:0] rank_key(rec_t r);
    logic [TOTAL_W-1:0] total;
    total = TOTAL_W'(r.first) + TOTAL_W'(r.second);
    return {r.group, ~total, ~r.first, r.id};
  endfunction

  function automatic void rank_record(logic [ID_W-1:0] id, logic [SCORE_W-1:0] f,
                                      logic [SCORE_W-1:0] s, logic fin);
    rec_t    r;
    int      pos;
    result_t e;
    if (f >= low_line_q && s >= low_line_q) begin
      r.id     = id;
      r.first  = f;
      r.second = s;
      if (f >= high_line_q && s >= high_line_q) r.group = GRP_BOTH_HIGH;
      else if (f >= high_line_q)                r.group = GRP_FIRST_HIGH;
      else if (f >= s)                          r.group = GRP_FIRST_GE;
      else                                      r.group = GRP_OTHER;
      if (sorted_chain.size() >= MAX_RECORDS_DEF) begin
        chain_dropped = 1'b1;
      end else begin
        pos = 0;
        while (pos < sorted_chain.size() && rank_key(r) >= rank_key(sorted_chain[pos])) pos++;
        sorted_chain.insert(pos, r);
      end
    end
    if (fin) begin
      e       = '0;
      e.kind  = KIND_COUNT;
      e.count = CNT_W'(sorted_chain.size());
      e.ovf   = chain_dropped;
      e.last  = (sorted_chain.size() == 0);
      due_results.push_back(e);
      foreach (sorted_chain[k]) begin
        e        = '0;
        e.kind   = KIND_RECORD;
        e.ovf    = chain_dropped;
        e.id     = sorted_chain[k].id;
        e.first  = sorted_chain[k].first;
        e.second = sorted_chain[k].second;
        e.group  = sorted_chain[k].group;
        e.last   = (k == sorted_chain.size() - 1);
        due_results.push_back(e);
      end
      sorted_chain.delete();
      chain_dropped = 1'b0;
    end
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    errors++;
    if (errors <= PRINT_LIMIT)
      $display("%0t mismatch on %s: got %0h, expected %0h", $time, what, got, want);
  endtask

  always @(posedge clk) begin : result_monitor
    result_t got;
    result_t want;
    if (rst_n) begin
      if (rec_ch.valid && rec_ch.ready)
        rank_record(rec_ch.record_id, rec_ch.first_score, rec_ch.second_score,
                    rec_ch.final_record);
      if (res_ch.valid && res_ch.ready) begin
        got.kind   = res_ch.item_kind;
        got.count  = res_ch.admitted_count;
        got.ovf    = res_ch.overflow_flag;
        got.id     = res_ch.out_id;
        got.first  = res_ch.out_first_score;
        got.second = res_ch.out_second_score;
        got.group  = res_ch.out_group;
        got.last   = res_ch.last_result;
        if (due_results.size() == 0) begin
          report_mismatch("unexpected result item (id)", got.id, 0);
        end else begin
          want = due_results.pop_front();
          results_checked++;
          if (got.kind !== want.kind)     report_mismatch("item_kind", got.kind, want.kind);
          if (got.count !== want.count)   report_mismatch("admitted_count", got.count, want.count);
          if (got.ovf !== want.ovf)       report_mismatch("overflow_flag", got.ovf, want.ovf);
          if (got.id !== want.id)         report_mismatch("out_id", got.id, want.id);
          if (got.first !== want.first)   report_mismatch("out_first_score", got.first, want.first);
          if (got.second !== want.second)
            report_mismatch("out_second_score", got.second, want.second);
          if (got.group !== want.group)   report_mismatch("out_group", got.group, want.group);
          if (got.last !== want.last)     report_mismatch("last_result", got.last, want.last);
        end
      end
    end
  end

  initial begin : receiver
    int stall_left;
    stall_left   = 0;
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_pending) begin
        stall_left   = HOLD_CYCLES;
        hold_pending = 1'b0;
      end
      if (stall_left > 0) begin
        res_ch.ready = 1'b0;
        stall_left--;
      end else begin
        res_ch.ready = steady || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  task automatic send_record(logic [ID_W-1:0] id, logic [SCORE_W-1:0] f,
                             logic [SCORE_W-1:0] s, logic fin);
    @(negedge clk);
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      rec_ch.valid = 1'b0;
      @(negedge clk);
    end
    rec_ch.valid        = 1'b1;
    rec_ch.record_id    = id;
    rec_ch.first_score  = f;
    rec_ch.second_score = s;
    rec_ch.final_record = fin;
    @(posedge clk);
    while (!rec_ch.ready) @(posedge clk);
    records_sent++;
    if (fin) sets_sent++;
  endtask

  task automatic drain_results();
    @(negedge clk);
    rec_ch.valid = 1'b0;
    while (due_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == REG_LOW_LINE) low_line_q = val;
    else                     high_line_q = val;
  endtask

  task automatic set_lines(logic [CFG_DATA_W-1:0] low, logic [CFG_DATA_W-1:0] high);
    drain_results();
    write_reg(REG_LOW_LINE, low);
    write_reg(REG_HIGH_LINE, high);
  endtask

  function automatic logic [SCORE_W-1:0] near_line(int line);
    int v;
    v = line + int'($urandom_range(0, 4)) - 2;
    if (v < 0)   v = 0;
    if (v > 255) v = 255;
    return v[SCORE_W-1:0];
  endfunction

  task automatic pick_scores(output logic [SCORE_W-1:0] f, output logic [SCORE_W-1:0] s);
    int mode;
    int d;
    mode = $urandom_range(0, 9);
    case (mode)
      0, 1, 2: begin
        f = SCORE_W'($urandom);
        s = SCORE_W'($urandom);
      end
      3, 4: begin
        f = near_line(low_line_q);
        s = $urandom_range(0, 1) ? near_line(low_line_q) : near_line(high_line_q);
      end
      5, 6: begin
        f = near_line(high_line_q);
        s = $urandom_range(0, 1) ? near_line(high_line_q) : SCORE_W'($urandom);
      end
      7: begin
        // equal totals, different split
        d = $urandom_range(0, 3);
        f = SCORE_W'(120 + d);
        s = SCORE_W'(120 - d);
      end
      8: begin
        f = (low_line_q > 0) ? SCORE_W'($urandom_range(0, low_line_q - 1)) : SCORE_W'($urandom);
        s = SCORE_W'($urandom);
        if ($urandom_range(0, 1)) {f, s} = {s, f};
      end
      default: begin
        f = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        s = f;
      end
    endcase
  endtask

  task automatic test_default_lines();
    send_record(32'd5, 8'd59, 8'd90, 1'b0);
    send_record(32'd6, 8'd90, 8'd59, 1'b0);
    send_record(32'd7, 8'd60, 8'd60, 1'b0);
    send_record(32'd8, 8'd80, 8'd80, 1'b0);
    send_record(32'd9, 8'd80, 8'd79, 1'b0);
    send_record(32'd10, 8'd79, 8'd80, 1'b0);
    send_record(32'hFFFF_FFFF, 8'd255, 8'd255, 1'b0);
    send_record(32'd0, 8'd255, 8'd255, 1'b0);
    send_record(32'd3, 8'd100, 8'd90, 1'b0);
    send_record(32'd4, 8'd90, 8'd100, 1'b0);
    send_record(32'd11, 8'd70, 8'd65, 1'b0);
    send_record(32'd12, 8'd0, 8'd0, 1'b1);
    // empty set, then a set of one
    send_record(32'd13, 8'd0, 8'd0, 1'b1);
    send_record(32'd14, 8'd61, 8'd61, 1'b1);
  endtask

  task automatic test_line_extremes();
    set_lines(8'd0, 8'd0);
    send_record(32'h8000_0000, 8'd0, 8'd0, 1'b0);
    send_record(32'h7FFF_FFFF, 8'd255, 8'd0, 1'b1);
    set_lines(8'd255, 8'd255);
    send_record(32'd1, 8'd255, 8'd255, 1'b0);
    send_record(32'd2, 8'd254, 8'd255, 1'b0);
    send_record(32'd3, 8'd255, 8'd254, 1'b1);
    set_lines(8'd0, 8'd255);
    send_record(32'd21, 8'd255, 8'd0, 1'b0);
    send_record(32'd22, 8'd0, 8'd255, 1'b0);
    send_record(32'd23, 8'd0, 8'd0, 1'b0);
    send_record(32'd24, 8'd255, 8'd255, 1'b1);
    set_lines(8'd255, 8'd0);
    send_record(32'd31, 8'd255, 8'd255, 1'b1);
  endtask

  task automatic test_full_chain();
    logic [SCORE_W-1:0] f;
    logic [SCORE_W-1:0] s;
    set_lines(8'd0, 8'd128);
    for (int i = 0; i < MAX_RECORDS_DEF; i++) begin
      pick_scores(f, s);
      send_record($urandom, f, s, i == MAX_RECORDS_DEF - 1);
    end
    for (int i = 0; i < MAX_RECORDS_DEF + 3; i++) begin
      pick_scores(f, s);
      send_record($urandom, f, s, i == MAX_RECORDS_DEF + 2);
    end
  endtask

  task automatic test_output_hold_off();
    logic [SCORE_W-1:0] f;
    logic [SCORE_W-1:0] s;
    set_lines(8'd40, 8'd150);
    hold_pending = 1'b1;
    for (int i = 0; i < 12; i++) begin
      pick_scores(f, s);
      send_record($urandom, f, s, i == 11);
    end
    for (int i = 0; i < 8; i++) begin
      pick_scores(f, s);
      send_record($urandom, f, s, i == 7);
    end
    drain_results();
  endtask

  task automatic test_random_sets();
    int                 set_no;
    int                 size;
    logic [ID_W-1:0]    id;
    logic [SCORE_W-1:0] f;
    logic [SCORE_W-1:0] s;
    logic [SCORE_W-1:0] low;
    set_no = 0;
    while (records_sent < RANDOM_ITEMS) begin
      if (set_no % 5 == 4) begin
        case ($urandom_range(0, 5))
          0:       low = 8'd0;
          1:       low = 8'd255;
          default: low = SCORE_W'($urandom_range(0, 110));
        endcase
        set_lines(low, $urandom_range(0, 3) == 0 ? 8'hFF : SCORE_W'($urandom));
      end
      steady = (set_no >= 12 && set_no < 18);
      size   = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 40) : $urandom_range(1, 10);
      for (int i = 0; i < size; i++) begin
        pick_scores(f, s);
        id = ($urandom_range(0, 3) == 0) ? ID_W'($urandom_range(0, 3)) : ID_W'($urandom);
        send_record(id, f, s, i == size - 1);
      end
      set_no++;
    end
    steady = 1'b0;
  endtask

  initial begin
    rst_n               = 1'b0;
    cfg_we              = 1'b0;
    cfg_index           = '0;
    cfg_wdata           = '0;
    rec_ch.valid        = 1'b0;
    rec_ch.record_id    = '0;
    rec_ch.first_score  = '0;
    rec_ch.second_score = '0;
    rec_ch.final_record = 1'b0;
    steady              = 1'b0;
    errors              = 0;
    sets_sent           = 0;
    records_sent        = 0;
    results_checked     = 0;
    cycle_count         = 0;
    low_line_q          = LOW_LINE_RST;
    high_line_q         = HIGH_LINE_RST;
    chain_dropped       = 1'b0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    test_default_lines();
    test_line_extremes();
    test_full_chain();
    test_output_hold_off();
    test_random_sets();

    drain_results();
    repeat (8) @(negedge clk);
    if (due_results.size() != 0)
      report_mismatch("result items never seen", due_results.size(), 0);
    $display("sent %0d records in %0d sets; %0d result items checked, incl. overflow and stalls",
             records_sent, sets_sent, results_checked);
    if (errors == 0) begin
      $display("threshold_classify_multikey_sorter_tb: clean");
    end else begin
      $display("threshold_classify_multikey_sorter_tb: errors");
    end
    $finish;
  end

endmodule
